FILE: rtl/mbb_pkg.sv
// Package: shared types and constants of the makespan branch-and-bound scheduler.
package mbb_pkg;

  localparam int unsigned LOAD_W = 20;
  localparam int unsigned COST_W = 16;

  localparam logic [1:0] CFG_TASK_COUNT    = 2'd0;
  localparam logic [1:0] CFG_MACHINE_COUNT = 2'd1;
  localparam logic [1:0] CFG_INITIAL_BOUND = 2'd2;

  localparam logic [4:0]  RST_TASK_COUNT    = 5'd16;
  localparam logic [3:0]  RST_MACHINE_COUNT = 4'd2;
  localparam logic [19:0] RST_INITIAL_BOUND = 20'd100000;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_ENTER = 7'b0000010,
    ST_PEAK  = 7'b0000100,
    ST_TRY   = 7'b0001000,
    ST_UNDO  = 7'b0010000,
    ST_COPY  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

endpackage

FILE: rtl/makespan_branch_and_bound.sv
// Top level: exact multiprocessor makespan scheduler by depth-first branch and bound.
// Costs are taken one per cycle while the block is idle. After the cost of the last task
// the block stalls its input and runs the search: it first clears the loads; each descent
// into a tree node reads cost and load, adds, then runs a peak scan over the load memory,
// one machine a cycle; each step back up removes the cost and tries the next machine, and a
// new best assignment is copied. The results then leave in task order, each held until the
// output side takes it; the next result is read only after the previous one is taken.
module makespan_branch_and_bound
  import mbb_pkg::*;
#(
  parameter int unsigned MAX_TASKS    = 16,
  parameter int unsigned MAX_MACHINES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_task_cost,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_task_index,
  output logic [2:0]  out_machine_index,
  output logic        out_solution_found,
  output logic [19:0] out_makespan,
  output logic        out_last_result
);

  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned MW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned KW = $clog2(MAX_MACHINES + 1);

  logic [4:0]  task_count_r;
  logic [3:0]  machine_count_r;
  logic [19:0] initial_bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r    <= RST_TASK_COUNT;
      machine_count_r <= RST_MACHINE_COUNT;
      initial_bound_r <= RST_INITIAL_BOUND;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TASK_COUNT:    task_count_r    <= cfg_data[4:0];
        CFG_MACHINE_COUNT: machine_count_r <= cfg_data[3:0];
        CFG_INITIAL_BOUND: initial_bound_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_eff;
  logic [KW-1:0] k_eff;
  always_comb begin
    if (task_count_r == 5'd0) n_eff = CW'(1);
    else if (32'(task_count_r) > MAX_TASKS) n_eff = CW'(MAX_TASKS);
    else n_eff = CW'(task_count_r);
    if (machine_count_r == 4'd0) k_eff = KW'(1);
    else if (32'(machine_count_r) > MAX_MACHINES) k_eff = KW'(MAX_MACHINES);
    else k_eff = KW'(machine_count_r);
  end

  // memories
  logic [COST_W-1:0] cost_mem [MAX_TASKS];
  logic [LOAD_W-1:0] load_mem [MAX_MACHINES];
  logic [MW-1:0]     choice_mem [MAX_TASKS];
  logic [MW-1:0]     best_mem [MAX_TASKS];

  state_t        state_r;
  logic [CW-1:0] loaded_r;
  logic [CW-1:0] depth_r;
  logic [KW-1:0] scan_r;
  logic [LOAD_W-1:0] peak_r, best_r;
  logic          found_r;
  logic [CW-1:0] idx_r;
  logic [LOAD_W-1:0] cost_rd_r, load_rd_r;
  logic [MW-1:0] choice_rd_r;
  logic [MW-1:0] copy_rd_r;
  logic          copy_v_r;
  logic [CW-1:0] copy_wa_r;
  logic          clear_r;

  // Stage substates kept in phase_r
  logic [1:0] phase_r;

  logic [LOAD_W-1:0] cost_q, load_q;
  logic [MW-1:0]     choice_q, best_q;
  logic [TW-1:0]     cost_ra, choice_ra, best_ra, choice_wa, best_wa;
  logic [MW-1:0]     load_ra, load_wa, choice_wd;
  logic              load_we, choice_we, best_we;
  logic [LOAD_W-1:0] load_wd;

  assign in_stall = (state_r != ST_LOAD);
  wire in_xfer  = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (in_xfer && loaded_r < CW'(MAX_TASKS))
      cost_mem[loaded_r[TW-1:0]] <= in_task_cost;
    cost_q <= LOAD_W'(cost_mem[cost_ra]);
    if (load_we) load_mem[load_wa] <= load_wd;
    load_q <= load_mem[load_ra];
    if (choice_we) choice_mem[choice_wa] <= choice_wd;
    choice_q <= choice_mem[choice_ra];
    if (best_we) best_mem[best_wa] <= copy_rd_r;
    best_q <= best_mem[best_ra];
  end

  // Search: each level walks its choice via choice_mem; ENTER reads cost and
  // current choice load, TRY adds, PEAK scans loads, UNDO removes and advances.
  logic [MW-1:0] cur_m;
  assign cur_m = choice_rd_r;

  always_comb begin
    cost_ra   = depth_r[TW-1:0];
    choice_ra = depth_r[TW-1:0];
    load_ra   = scan_r[MW-1:0];
    best_ra   = idx_r[TW-1:0];
    load_we = 1'b0; load_wa = cur_m; load_wd = '0;
    choice_we = 1'b0; choice_wa = depth_r[TW-1:0]; choice_wd = '0;
    best_we = copy_v_r; best_wa = copy_wa_r[TW-1:0];
    if (clear_r) begin
      load_we = 1'b1; load_wa = scan_r[MW-1:0]; load_wd = '0;
    end
    case (state_r)
      ST_ENTER: begin
        choice_we = 1'b1; choice_wd = cur_m;
      end
      ST_TRY: begin
        load_we = 1'b1; load_wd = load_rd_r + cost_rd_r;
        load_wa = cur_m;
      end
      ST_UNDO: begin
        load_we = (phase_r == 2'd3); load_wd = load_q - cost_rd_r;
        load_wa = cur_m;
      end
      ST_COPY: choice_ra = idx_r[TW-1:0];
      default: ;
    endcase
    if (state_r == ST_ENTER || (state_r == ST_UNDO && phase_r == 2'd2)) load_ra = cur_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      loaded_r <= '0;
      depth_r <= '0;
      scan_r <= '0;
      found_r <= 1'b0;
      idx_r <= '0;
      phase_r <= '0;
      copy_v_r <= 1'b0;
      clear_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      copy_v_r <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            if (loaded_r + CW'(1) >= n_eff) begin
              loaded_r <= '0;
              best_r <= initial_bound_r;
              found_r <= 1'b0;
              depth_r <= '0;
              scan_r <= '0;
              clear_r <= 1'b1;
              peak_r <= '0;
              phase_r <= 2'd0;
              state_r <= ST_PEAK;
            end else loaded_r <= loaded_r + CW'(1);
          end
        end
        // PEAK phase 0 with clear_r: zero loads; then evaluate node
        ST_PEAK: begin
          if (clear_r) begin
            if (scan_r == k_eff - KW'(1)) begin
              clear_r <= 1'b0;
              scan_r <= '0;
              peak_r <= '0;
              phase_r <= 2'd3;
            end else scan_r <= scan_r + KW'(1);
          end else if (phase_r == 2'd0) begin
            phase_r <= 2'd1;
            scan_r <= scan_r + KW'(1);
            peak_r <= '0;
          end else if (phase_r == 2'd1) begin
            if (load_q > peak_r) peak_r <= load_q;
            if (scan_r == k_eff) phase_r <= 2'd3;
            else scan_r <= scan_r + KW'(1);
          end else begin
            // node evaluation with peak_r
            scan_r <= '0;
            if (depth_r >= n_eff) begin
              if (peak_r < best_r) begin
                best_r <= peak_r;
                found_r <= 1'b1;
                idx_r <= '0;
                phase_r <= 2'd0;
                state_r <= ST_COPY;
              end else begin
                depth_r <= depth_r - CW'(1);
                phase_r <= 2'd0;
                state_r <= ST_UNDO;
              end
            end else if (peak_r >= best_r) begin
              if (depth_r == '0) begin
                idx_r <= '0; phase_r <= 2'd0; state_r <= ST_EMIT;
              end else begin
                depth_r <= depth_r - CW'(1);
                phase_r <= 2'd0;
                state_r <= ST_UNDO;
              end
            end else begin
              choice_rd_r <= '0;
              phase_r <= 2'd1;
              state_r <= ST_ENTER;
            end
          end
        end
        // ENTER: write choice, read cost and load of cur_m
        ST_ENTER: begin
          if (phase_r == 2'd1) begin
            phase_r <= 2'd2;
          end else begin
            cost_rd_r <= cost_q;
            load_rd_r <= load_q;
            state_r <= ST_TRY;
          end
        end
        ST_TRY: begin
          depth_r <= depth_r + CW'(1);
          scan_r <= '0;
          phase_r <= 2'd0;
          state_r <= ST_PEAK;
        end
        // UNDO: phase0 issue reads at depth_r, phase1 capture choice, phase2 loads
        ST_UNDO: begin
          if (phase_r == 2'd0) phase_r <= 2'd1;
          else if (phase_r == 2'd1) begin
            choice_rd_r <= choice_q;
            cost_rd_r <= cost_q;
            phase_r <= 2'd2;
          end else if (phase_r == 2'd2) begin
            phase_r <= 2'd3;
          end else begin
            if (32'(choice_rd_r) + 1 < 32'(k_eff)) begin
              choice_rd_r <= choice_rd_r + MW'(1);
              phase_r <= 2'd1;
              state_r <= ST_ENTER;
            end else if (depth_r == '0) begin
              idx_r <= '0; phase_r <= 2'd0; state_r <= ST_EMIT;
            end else begin
              depth_r <= depth_r - CW'(1);
              phase_r <= 2'd0;
            end
          end
        end
        ST_COPY: begin
          if (phase_r == 2'd0) phase_r <= 2'd1;
          else begin
            copy_rd_r <= choice_q;
            copy_v_r <= 1'b1;
            copy_wa_r <= idx_r - CW'(1);
          end
          if (idx_r == n_eff) begin
            idx_r <= '0;
            depth_r <= depth_r - CW'(1);
            phase_r <= 2'd0;
            state_r <= ST_UNDO;
          end else idx_r <= idx_r + CW'(1);
        end
        ST_EMIT: begin
          if (phase_r == 2'd0) begin
            phase_r <= 2'd1;
          end else if (phase_r == 2'd1) begin
            out_valid <= 1'b1;
            out_task_index <= 4'(idx_r);
            out_machine_index <= found_r ? 3'(best_q) : 3'd0;
            out_solution_found <= found_r;
            out_makespan <= best_r;
            out_last_result <= (idx_r + CW'(1) == n_eff);
            phase_r <= 2'd2;
          end else if (out_xfer) begin
            out_valid <= 1'b0;
            if (out_last_result) begin
              idx_r <= '0; state_r <= ST_LOAD;
            end else begin
              idx_r <= idx_r + CW'(1);
              phase_r <= 2'd0;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // The copy pipeline writes entry idx-1 with data read at idx-1; read address idx_r
  // at phase 0 lands in the next cycle, so the first write uses read of entry 0.

  property p_no_out_in_load;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_LOAD) |-> !out_valid;
  endproperty
  a_no_out_in_load: assert property (p_no_out_in_load) else $error("output in load");

  property p_best_le_bound;
    @(posedge clk) disable iff (!rst_n)
      (found_r && state_r == ST_EMIT) |-> (best_r < initial_bound_r);
  endproperty
  a_best_le_bound: assert property (p_best_le_bound) else $error("best above bound");

  property p_depth_range;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_LOAD) |-> (depth_r <= n_eff);
  endproperty
  a_depth_range: assert property (p_depth_range) else $error("depth out of range");

endmodule
